[rtl/keyframe_sampler_core_assert.svh]
// Assertion macros used by the checker file of the keyframe sampler.
`ifndef KEYFRAME_SAMPLER_CORE_ASSERT_SVH
`define KEYFRAME_SAMPLER_CORE_ASSERT_SVH

// A property that is checked only outside reset.
`define KFS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("keyframe sampler check failed");

// A property that is checked at every edge, reset included.
`define KFS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("keyframe sampler check failed during reset");

`endif

[rtl/kfs_pkg.sv]
package kfs_pkg;

    localparam int TIME_W      = 32;
    localparam int FRAME_W     = 12;
    localparam int BLEND_W     = 17;
    localparam int LERP_W      = 16;
    localparam int MODE_W      = 2;
    localparam int FCOUNT_W    = 13;
    localparam int DUR_W       = 31;
    localparam int LEVELS_W    = 10;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_FRAMES_DEF = 4096;

    localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRAP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;

    localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_MODE      = 3'd0,
        CFG_FRAME_COUNT    = 3'd1,
        CFG_DURATION       = 3'd2,
        CFG_DURATION_RECIP = 3'd3,
        CFG_BLEND_LEVELS   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0]   play_mode;
        logic [FCOUNT_W-1:0] frame_count;
        logic [DUR_W-1:0]    duration;
        logic [DUR_W-1:0]    duration_recip;
        logic [LEVELS_W-1:0] blend_levels;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] cur_frame;
        logic [FRAME_W-1:0] next_frame;
        logic [BLEND_W-1:0] blend;
        logic               no_anim;
    } map_res_t;

endpackage

[rtl/kfs_map.sv]
module kfs_map #(
    parameter int MAX_FRAMES = kfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kfs_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [kfs_pkg::TIME_W-1:0] play_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output kfs_pkg::map_res_t                 out_res
);

    localparam int FC_W_RAW = $clog2(MAX_FRAMES + 1);
    localparam int FC_W = (FC_W_RAW < kfs_pkg::FCOUNT_W) ? FC_W_RAW : kfs_pkg::FCOUNT_W;
    localparam int S_W = 32 + FC_W;

    logic [FC_W-1:0] fc;
    logic [FC_W-1:0] last;
    logic            fc_zero;
    logic            fc_one;

    logic hold_a;
    logic hold_b;
    logic hold_c;

    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;

    logic signed [63:0] prod_a;
    logic [62:0]        a_u_reg;
    logic               a_neg_reg;
    logic               a_le0_reg;
    logic               a_ge_dur_reg;

    logic [S_W-1:0] s_b;
    logic [32:0]    neg33;
    logic [S_W-1:0] b_s_reg;
    logic           b_neg_reg;
    logic           b_le0_reg;
    logic           b_ge_dur_reg;
    logic           b_hi_nz_reg;
    logic           b_odd_reg;

    logic [FC_W-1:0]   key;
    logic [FC_W-1:0]   key_inc;
    logic [15:0]       lerp;
    kfs_pkg::map_res_t c_res_next;
    kfs_pkg::map_res_t c_res_reg;

    always_comb
    begin
        if (32'(cfg.frame_count) > 32'(MAX_FRAMES))
        begin
            fc = FC_W'(MAX_FRAMES);
        end
        else
        begin
            fc = cfg.frame_count[FC_W-1:0];
        end
    end

    assign last    = fc - FC_W'(1);
    assign fc_zero = (fc == '0);
    assign fc_one  = (fc == FC_W'(1));

    assign hold_c   = c_valid_reg && out_stall;
    assign hold_b   = b_valid_reg && hold_c;
    assign hold_a   = a_valid_reg && hold_b;
    assign in_stall = hold_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (!hold_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (!hold_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (!hold_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    assign prod_a = 64'(play_time) * 64'($signed({1'b0, cfg.duration_recip}));

    always_ff @(posedge clk)
    begin
        if (!hold_a)
        begin
            a_u_reg      <= prod_a[62:0];
            a_neg_reg    <= play_time[31];
            a_le0_reg    <= play_time[31] || (play_time == '0);
            a_ge_dur_reg <= !play_time[31] && (play_time[30:0] >= cfg.duration);
        end
    end

    assign s_b   = S_W'(a_u_reg[31:0]) * S_W'(last);
    assign neg33 = 33'd0 - a_u_reg[32:0];

    always_ff @(posedge clk)
    begin
        if (!hold_b)
        begin
            b_s_reg      <= s_b;
            b_neg_reg    <= a_neg_reg;
            b_le0_reg    <= a_le0_reg;
            b_ge_dur_reg <= a_ge_dur_reg;
            b_hi_nz_reg  <= |a_u_reg[62:32];
            b_odd_reg    <= a_neg_reg ? neg33[32] : a_u_reg[32];
        end
    end

    assign key     = b_s_reg[32 +: FC_W];
    assign key_inc = key + FC_W'(1);
    assign lerp    = b_s_reg[31:16];

    always_comb
    begin
        logic [FC_W-1:0]             cur;
        logic [FC_W-1:0]             nxt;
        logic [kfs_pkg::BLEND_W-1:0] bl;
        logic                        na;
        cur = '0;
        nxt = '0;
        bl  = '0;
        na  = 1'b0;
        priority if (fc_zero)
        begin
            na = 1'b1;
        end
        else if (fc_one)
        begin
            na = 1'b0;
        end
        else if (cfg.play_mode == kfs_pkg::MODE_WRAP || cfg.play_mode == kfs_pkg::MODE_MIRROR)
        begin
            if (b_neg_reg)
            begin
                cur = key_inc;
                nxt = key;
                bl  = kfs_pkg::BLEND_ONE - {1'b0, lerp};
            end
            else
            begin
                cur = key;
                nxt = key_inc;
                bl  = {1'b0, lerp};
            end
            if (cfg.play_mode == kfs_pkg::MODE_MIRROR && b_odd_reg)
            begin
                cur = last - cur;
                nxt = last - nxt;
            end
        end
        else if (b_le0_reg)
        begin
            na = 1'b0;
        end
        else if (b_ge_dur_reg || b_hi_nz_reg)
        begin
            cur = last;
            nxt = last;
        end
        else
        begin
            cur = key;
            nxt = key_inc;
            bl  = {1'b0, lerp};
        end
        c_res_next.cur_frame  = kfs_pkg::FRAME_W'(cur);
        c_res_next.next_frame = kfs_pkg::FRAME_W'(nxt);
        c_res_next.blend      = bl;
        c_res_next.no_anim    = na;
    end

    always_ff @(posedge clk)
    begin
        if (!hold_c)
        begin
            c_res_reg <= c_res_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_res   = c_res_reg;

endmodule

[rtl/kfs_quant.sv]
module kfs_quant (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kfs_pkg::LEVELS_W-1:0]    blend_levels,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  kfs_pkg::map_res_t               in_res,
    output logic                            out_valid,
    input  logic                            out_stall,
    output kfs_pkg::map_res_t               out_res
);

    localparam int NDIV  = 4;
    localparam int STEPS = kfs_pkg::LERP_W / NDIV;
    localparam int NST   = NDIV + 1;
    localparam int LW    = kfs_pkg::LEVELS_W;
    localparam int QW    = kfs_pkg::LERP_W;
    localparam int PW    = kfs_pkg::BLEND_W + LW;

    // One restoring division step per quotient bit, STEPS bits per stage.
    function automatic logic [LW+QW-1:0] div_steps(
        input logic [LW-1:0] r_in,
        input logic [QW-1:0] q_in,
        input logic [LW-1:0] d
    );
        logic [LW-1:0] r;
        logic [QW-1:0] q;
        logic [LW:0]   t;
        r = r_in;
        q = q_in;
        for (int j = 0; j < STEPS; j++)
        begin
            t = {r, 1'b0};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
                r = t[LW-1:0];
                q = {q[QW-2:0], 1'b1};
            end
            else
            begin
                r = t[LW-1:0];
                q = {q[QW-2:0], 1'b0};
            end
        end
        return {r, q};
    endfunction

    logic [NST-1:0]    hold;
    logic [NST-1:0]    valid_reg;
    kfs_pkg::map_res_t res_reg  [0:NST-1];
    logic              full_reg [0:NDIV-1];
    logic [LW-1:0]     r_reg    [0:NDIV-1];
    logic [QW-1:0]     quo_reg  [0:NDIV-1];
    logic [PW-1:0]     prod;

    always_comb
    begin
        hold[NST-1] = valid_reg[NST-1] && out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            hold[k] = valid_reg[k] && hold[k+1];
        end
    end

    assign in_stall = hold[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (!hold[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (!hold[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // A full-scale blend quantizes to exactly one, so it skips the divider.
    assign prod = PW'(in_res.blend) * PW'(blend_levels);

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            res_reg[0]  <= in_res;
            full_reg[0] <= in_res.blend[kfs_pkg::BLEND_W-1];
            r_reg[0]    <= in_res.blend[kfs_pkg::BLEND_W-1] ? '0 : prod[QW +: LW];
            quo_reg[0]  <= '0;
        end
    end

    for (genvar k = 1; k <= NDIV; k++)
    begin : g_div
        logic [LW+QW-1:0] step;

        assign step = div_steps(r_reg[k-1], quo_reg[k-1], blend_levels);

        if (k < NDIV)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (!hold[k])
                begin
                    res_reg[k]  <= res_reg[k-1];
                    full_reg[k] <= full_reg[k-1];
                    r_reg[k]    <= step[QW +: LW];
                    quo_reg[k]  <= step[QW-1:0];
                end
            end
        end
        else
        begin : g_last
            kfs_pkg::map_res_t fin;

            always_comb
            begin
                fin = res_reg[k-1];
                if (blend_levels == '0)
                begin
                    fin.blend = res_reg[k-1].blend;
                end
                else if (full_reg[k-1])
                begin
                    fin.blend = kfs_pkg::BLEND_ONE;
                end
                else
                begin
                    fin.blend = {1'b0, step[QW-1:0]};
                end
            end

            always_ff @(posedge clk)
            begin
                if (!hold[k])
                begin
                    res_reg[k] <= fin;
                end
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_res   = res_reg[NST-1];

endmodule

[rtl/keyframe_sampler_core.sv]
// Keyframe sampler: each request carries a signed Q16.16 playback time and
// returns the current keyframe, the keyframe blended toward, a Q1.16 blend
// fraction and a no-animation flag, computed for the clamp, wrap or mirror
// play mode held in the configuration registers. The block accepts one
// request every cycle unless in_stall is high. The pipeline has three
// mapping stages (time times reciprocal, fraction times last frame index,
// frame selection), one stage for the quantizer multiply and four divider
// stages that each resolve four bits of the quantized blend. A stall holds
// only the occupied stages that form an unbroken run up to the output;
// stages before an empty stage keep advancing. Configuration must only be written
// while no request is in flight.
module keyframe_sampler_core #(
    parameter int MAX_FRAMES = kfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kfs_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [kfs_pkg::TIME_W-1:0]  play_time,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [kfs_pkg::FRAME_W-1:0]        cur_frame,
    output logic [kfs_pkg::FRAME_W-1:0]        next_frame,
    output logic [kfs_pkg::BLEND_W-1:0]        blend,
    output logic                               no_anim
);

    kfs_pkg::cfg_t     cfg_reg;
    kfs_pkg::map_res_t map_res;
    kfs_pkg::map_res_t q_res;
    logic              map_valid;
    logic              map_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kfs_pkg::CFG_PLAY_MODE:
                begin
                    cfg_reg.play_mode <= cfg_data[kfs_pkg::MODE_W-1:0];
                end
                kfs_pkg::CFG_FRAME_COUNT:
                begin
                    cfg_reg.frame_count <= cfg_data[kfs_pkg::FCOUNT_W-1:0];
                end
                kfs_pkg::CFG_DURATION:
                begin
                    cfg_reg.duration <= cfg_data[kfs_pkg::DUR_W-1:0];
                end
                kfs_pkg::CFG_DURATION_RECIP:
                begin
                    cfg_reg.duration_recip <= cfg_data[kfs_pkg::DUR_W-1:0];
                end
                kfs_pkg::CFG_BLEND_LEVELS:
                begin
                    cfg_reg.blend_levels <= cfg_data[kfs_pkg::LEVELS_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    kfs_map #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .play_time (play_time),
        .out_valid (map_valid),
        .out_stall (map_stall),
        .out_res   (map_res)
    );

    kfs_quant u_quant (
        .clk          (clk),
        .rst_n        (rst_n),
        .blend_levels (cfg_reg.blend_levels),
        .in_valid     (map_valid),
        .in_stall     (map_stall),
        .in_res       (map_res),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_res      (q_res)
    );

    assign cur_frame  = q_res.cur_frame;
    assign next_frame = q_res.next_frame;
    assign blend      = q_res.blend;
    assign no_anim    = q_res.no_anim;

endmodule

[rtl/kfs_checker.sv]
`include "keyframe_sampler_core_assert.svh"

module kfs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [kfs_pkg::FRAME_W-1:0] cur_frame,
    input logic [kfs_pkg::FRAME_W-1:0] next_frame,
    input logic [kfs_pkg::BLEND_W-1:0] blend,
    input logic                        no_anim
);

    `KFS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(cur_frame) && $stable(next_frame) && $stable(blend) && $stable(no_anim))
    `KFS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid)
    `KFS_ASSERT(a_no_stall_through, !out_stall |-> !in_stall)
    `KFS_ASSERT(a_no_anim_zero, out_valid && no_anim |-> cur_frame == '0 && next_frame == '0 && blend == '0)
    `KFS_ASSERT(a_blend_range, out_valid |-> blend <= kfs_pkg::BLEND_ONE)

endmodule

bind keyframe_sampler_core kfs_checker u_kfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cur_frame  (cur_frame),
    .next_frame (next_frame),
    .blend      (blend),
    .no_anim    (no_anim)
);
